// ===== rtl/twwbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-way write-back cache package
// Sizes, derived widths, sequencer state codes and the backing memory
// index function used by the cache and its memories.
// ----------------------------------------------------------------------------
package twwbc_pkg;

   localparam int NUM_SETS   = 8;
   localparam int LINE_WORDS = 16;
   localparam int MEM_WORDS  = 16384;
   localparam int WAYS       = 2;

   localparam int ADDR_W   = 16;
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = 32;
   localparam int WADDR_W  = ADDR_W - 2;
   localparam int OFF_W    = $clog2(LINE_WORDS);
   localparam int SET_W    = $clog2(NUM_SETS);
   localparam int TAG_W    = WADDR_W - SET_W - OFF_W;
   localparam int WAY_W    = $clog2(WAYS);
   localparam int MEM_AW   = $clog2(MEM_WORDS);
   localparam int CNT_W    = OFF_W + 1;

   localparam int LINE_DEPTH = NUM_SETS * WAYS * LINE_WORDS;
   localparam int LINE_AW    = SET_W + WAY_W + OFF_W;

   localparam int STATE_W = 3;
   localparam logic [STATE_W-1:0] ST_CLEAR = 3'd0;
   localparam logic [STATE_W-1:0] ST_IDLE  = 3'd1;
   localparam logic [STATE_W-1:0] ST_LOOK  = 3'd2;
   localparam logic [STATE_W-1:0] ST_WB    = 3'd3;
   localparam logic [STATE_W-1:0] ST_FILL  = 3'd4;
   localparam logic [STATE_W-1:0] ST_DONE  = 3'd5;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_STORE = 1'b1;

   // Word addresses wrap modulo the backing memory size.
   function automatic logic [MEM_AW-1:0] mem_index(input logic [WADDR_W-1:0] waddr);
      logic [WADDR_W+MEM_AW-1:0] ext;
      ext = {{MEM_AW{1'b0}}, waddr};
      return ext[MEM_AW-1:0];
   endfunction

endpackage

// ===== rtl/twwbc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port, with the read data registered and
// held while no read is requested.
// ----------------------------------------------------------------------------
module twwbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/two_way_writeback_cache.sv =====
// ----------------------------------------------------------------------------
// Two-way set-associative write-back cache
// A hit completes from the lookup state: rsp_valid rises and req_ready
// returns together, so a new request is taken only once the last one has
// completed. A clean miss runs through lookup, a line fill from the backing
// memory and a completion state before its response. A dirty miss first runs
// a write-back of the victim over the line memory read port. A stalled
// response holds completion until the output register is free. After reset
// a clearing pass writes all ones into the backing memory, one word a cycle
// over all 16384 words, while req_ready stays low.
// ----------------------------------------------------------------------------
module two_way_writeback_cache
   import twwbc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic [ADDR_W-1:0]   req_address,
   input  logic [DATA_W-1:0]   req_write_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [DATA_W-1:0]   rsp_read_data,
   output logic                rsp_hit,
   output logic [COUNT_W-1:0]  rsp_hit_count,
   output logic [COUNT_W-1:0]  rsp_miss_count
);

   logic [STATE_W-1:0]  state_ff, state_in;
   logic                op_ff, op_in;
   logic [SET_W-1:0]    set_ff, set_in;
   logic [OFF_W-1:0]    off_ff, off_in;
   logic [TAG_W-1:0]    req_tag_ff, req_tag_in;
   logic [DATA_W-1:0]   wdata_ff, wdata_in;
   logic                hit_ff, hit_in;
   logic [WAY_W-1:0]    way_ff, way_in;
   logic [TAG_W-1:0]    vtag_ff, vtag_in;
   logic                vdirty_ff, vdirty_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [MEM_AW-1:0]   clr_ff, clr_in;
   logic [DATA_W-1:0]   fill_word_ff, fill_word_in;
   logic [TAG_W-1:0]    tags_ff [WAYS][NUM_SETS];
   logic [TAG_W-1:0]    tags_in [WAYS][NUM_SETS];
   logic [WAYS-1:0][NUM_SETS-1:0] valid_ff, valid_in;
   logic [WAYS-1:0][NUM_SETS-1:0] dirty_ff, dirty_in;
   logic [NUM_SETS-1:0] lru_ff, lru_in;
   logic [COUNT_W-1:0]  hit_cnt_ff, hit_cnt_in;
   logic [COUNT_W-1:0]  miss_cnt_ff, miss_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [DATA_W-1:0]   rsp_read_data_ff, rsp_read_data_in;

   logic [WADDR_W-1:0]  r_waddr;
   logic [OFF_W-1:0]    r_off;
   logic [SET_W-1:0]    r_set;
   logic [TAG_W-1:0]    r_tag;
   logic [WAYS-1:0]     match;
   logic                accept;
   logic                out_free;
   logic                fin;
   logic                cnt_last;
   logic [OFF_W-1:0]    cnt_m1;
   logic [WAY_W-1:0]    a_way;

   logic                line_we, line_re;
   logic [LINE_AW-1:0]  line_waddr, line_raddr;
   logic [DATA_W-1:0]   line_wdata, line_rdata;
   logic                mem_we, mem_re;
   logic [MEM_AW-1:0]   mem_waddr, mem_raddr;
   logic [DATA_W-1:0]   mem_wdata, mem_rdata;

   assign r_waddr = req_address[ADDR_W-1:2];
   assign r_off   = r_waddr[OFF_W-1:0];
   assign r_set   = r_waddr[OFF_W +: SET_W];
   assign r_tag   = r_waddr[WADDR_W-1 -: TAG_W];

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         match[w] = valid_ff[w][r_set] && (tags_ff[w][r_set] == r_tag);
      end
   end

   assign a_way     = match[0] ? WAY_W'(0) : (match[1] ? WAY_W'(1) : lru_ff[r_set]);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fin       = out_free && (((state_ff == ST_LOOK) && hit_ff) || (state_ff == ST_DONE));
   assign cnt_last  = (cnt_ff == CNT_W'(LINE_WORDS));
   assign cnt_m1    = cnt_ff[OFF_W-1:0] - OFF_W'(1);

   always_comb begin
      line_we    = 1'b0;
      line_waddr = {set_ff, way_ff, cnt_m1};
      line_wdata = mem_rdata;
      line_re    = 1'b0;
      line_raddr = {set_ff, way_ff, cnt_ff[OFF_W-1:0]};
      mem_we     = 1'b0;
      mem_waddr  = mem_index({vtag_ff, set_ff, cnt_m1});
      mem_wdata  = line_rdata;
      mem_re     = 1'b0;
      mem_raddr  = mem_index({req_tag_ff, set_ff, cnt_ff[OFF_W-1:0]});
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '1;
         end
         ST_IDLE: begin
            line_re    = accept;
            line_raddr = {r_set, a_way, r_off};
         end
         ST_WB: begin
            line_re = !cnt_last;
            mem_we  = (cnt_ff != '0);
         end
         ST_FILL: begin
            mem_re  = !cnt_last;
            line_we = (cnt_ff != '0);
         end
         default: begin
         end
      endcase
      if (fin && (op_ff == OP_STORE)) begin
         line_we    = 1'b1;
         line_waddr = {set_ff, way_ff, off_ff};
         line_wdata = wdata_ff;
      end
   end

   always_comb begin
      state_in         = state_ff;
      op_in            = op_ff;
      set_in           = set_ff;
      off_in           = off_ff;
      req_tag_in       = req_tag_ff;
      wdata_in         = wdata_ff;
      hit_in           = hit_ff;
      way_in           = way_ff;
      vtag_in          = vtag_ff;
      vdirty_in        = vdirty_ff;
      cnt_in           = cnt_ff;
      clr_in           = clr_ff;
      fill_word_in     = fill_word_ff;
      tags_in          = tags_ff;
      valid_in         = valid_ff;
      dirty_in         = dirty_ff;
      lru_in           = lru_ff;
      hit_cnt_in       = hit_cnt_ff;
      miss_cnt_in      = miss_cnt_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_hit_in       = rsp_hit_ff;
      rsp_read_data_in = rsp_read_data_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + MEM_AW'(1);
            if (clr_ff == MEM_AW'(MEM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in      = req_op;
               set_in     = r_set;
               off_in     = r_off;
               req_tag_in = r_tag;
               wdata_in   = req_write_data;
               hit_in     = |match;
               way_in     = a_way;
               vtag_in    = tags_ff[a_way][r_set];
               vdirty_in  = valid_ff[a_way][r_set] && dirty_ff[a_way][r_set];
               state_in   = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (!hit_ff) begin
               cnt_in   = '0;
               state_in = vdirty_ff ? ST_WB : ST_FILL;
            end
         end
         ST_WB: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if ((cnt_ff != '0) && (cnt_m1 == off_ff)) begin
               fill_word_in = mem_rdata;
            end
            if (cnt_last) begin
               tags_in[way_ff][set_ff]  = req_tag_ff;
               valid_in[way_ff][set_ff] = 1'b1;
               dirty_in[way_ff][set_ff] = 1'b0;
               state_in                 = ST_DONE;
            end
         end
         default: begin
         end
      endcase
      if (fin) begin
         state_in       = ST_IDLE;
         lru_in[set_ff] = ~way_ff;
         rsp_valid_in   = 1'b1;
         rsp_hit_in     = hit_ff;
         if (hit_ff) begin
            hit_cnt_in = (hit_cnt_ff == '1) ? hit_cnt_ff : hit_cnt_ff + COUNT_W'(1);
         end else begin
            miss_cnt_in = (miss_cnt_ff == '1) ? miss_cnt_ff : miss_cnt_ff + COUNT_W'(1);
         end
         if (op_ff == OP_STORE) begin
            dirty_in[way_ff][set_ff] = 1'b1;
            rsp_read_data_in         = '0;
         end else begin
            rsp_read_data_in = (state_ff == ST_LOOK) ? line_rdata : fill_word_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         lru_ff       <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int w = 0; w < WAYS; w++) begin
            for (int s = 0; s < NUM_SETS; s++) begin
               tags_ff[w][s] <= '0;
            end
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         lru_ff       <= lru_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         tags_ff      <= tags_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      set_ff           <= set_in;
      off_ff           <= off_in;
      req_tag_ff       <= req_tag_in;
      wdata_ff         <= wdata_in;
      hit_ff           <= hit_in;
      way_ff           <= way_in;
      vtag_ff          <= vtag_in;
      vdirty_ff        <= vdirty_in;
      fill_word_ff     <= fill_word_in;
      rsp_hit_ff       <= rsp_hit_in;
      rsp_read_data_ff <= rsp_read_data_in;
   end

   twwbc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (line_waddr),
      .wr_data (line_wdata),
      .rd_en   (line_re),
      .rd_addr (line_raddr),
      .rd_data (line_rdata)
   );

   twwbc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MEM_WORDS)
   ) u_backing_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_data  = rsp_read_data_ff;
   assign rsp_hit_count  = hit_cnt_ff;
   assign rsp_miss_count = miss_cnt_ff;

   // A line is never held in both ways of a set.
   assert property (@(posedge clock) disable iff (reset) accept |-> $onehot0(match))
      else $error("tag matches in both ways");

   // A completed miss leaves the allocated line valid.
   assert property (@(posedge clock) disable iff (reset)
      (fin && !hit_ff) |=> valid_ff[$past(way_ff)][$past(set_ff)])
      else $error("allocated line not valid after miss");

   // Write-back runs only for a valid, dirty victim.
   assert property (@(posedge clock) disable iff (reset) (state_ff == ST_WB) |-> vdirty_ff)
      else $error("write-back of a clean victim");

   // The counters move only when a transfer completes.
   assert property (@(posedge clock) disable iff (reset)
      !fin |=> ($stable(hit_cnt_ff) && $stable(miss_cnt_ff)))
      else $error("counter changed outside completion");

endmodule
